@@ rtl/sbfd_pkg.sv @@
`default_nettype none

package sbfd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned COUNT_W      = 5;
    localparam int unsigned CHAN_IDX_W   = 3;
    localparam int unsigned CHAN_VAL_W   = 11;
    localparam int unsigned KEPT_BYTES   = 10;
    localparam int unsigned KEPT_IDX_W   = $clog2(KEPT_BYTES);
    localparam int unsigned FRAME_LENGTH = 25;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h0F;

    // byte count at which each channel is complete
    localparam logic [COUNT_W:0] CH0_COUNT = 6'd3;
    localparam logic [COUNT_W:0] CH1_COUNT = 6'd4;
    localparam logic [COUNT_W:0] CH2_COUNT = 6'd6;
    localparam logic [COUNT_W:0] CH3_COUNT = 6'd7;
    localparam logic [COUNT_W:0] CH4_COUNT = 6'd8;
    localparam logic [COUNT_W:0] CH5_COUNT = 6'd10;

    typedef enum logic [CHAN_IDX_W-1:0] {
        CH_0 = 3'd0,
        CH_1 = 3'd1,
        CH_2 = 3'd2,
        CH_3 = 3'd3,
        CH_4 = 3'd4,
        CH_5 = 3'd5
    } chan_idx_t;

    typedef logic [BYTE_W-1:0] frame_byte_t;

    typedef struct packed {
        logic                  hit;
        chan_idx_t             index;
        logic [CHAN_VAL_W-1:0] value;
    } chan_result_t;

endpackage

`default_nettype wire

@@ rtl/sbfd_unpack.sv @@
`default_nettype none

module sbfd_unpack (
    input  wire logic [sbfd_pkg::COUNT_W:0]  count_inc,
    input  wire logic [sbfd_pkg::BYTE_W-1:0] cur_byte,
    input  wire sbfd_pkg::frame_byte_t       frame_bytes [sbfd_pkg::KEPT_BYTES],
    output sbfd_pkg::chan_result_t           result
);
    import sbfd_pkg::*;

    // the byte in flight completes the channel, so it stands in for the last stored one
    always_comb
    begin
        result = '0;
        unique case (count_inc)
            CH0_COUNT:
            begin
                result.hit   = 1'b1;
                result.index = CH_0;
                result.value = {cur_byte[2:0], frame_bytes[1]};
            end
            CH1_COUNT:
            begin
                result.hit   = 1'b1;
                result.index = CH_1;
                result.value = {cur_byte[5:0], frame_bytes[2][7:3]};
            end
            CH2_COUNT:
            begin
                result.hit   = 1'b1;
                result.index = CH_2;
                result.value = {cur_byte[0], frame_bytes[4], frame_bytes[3][7:6]};
            end
            CH3_COUNT:
            begin
                result.hit   = 1'b1;
                result.index = CH_3;
                result.value = {cur_byte[3:0], frame_bytes[5][7:1]};
            end
            CH4_COUNT:
            begin
                result.hit   = 1'b1;
                result.index = CH_4;
                result.value = {cur_byte[6:0], frame_bytes[6][7:4]};
            end
            CH5_COUNT:
            begin
                result.hit   = 1'b1;
                result.index = CH_5;
                result.value = {cur_byte[1:0], frame_bytes[8], frame_bytes[7][7]};
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/sbus_frame_channel_decoder.sv @@
// Frame channel decoder for an S.BUS-style serial stream. Received bytes enter on the rx
// channel, one per transaction; while idle the block waits for the start byte (programmed
// through the cfg channel, 0x0F after reset), then counts 25 frame bytes and goes idle again.
// Each of the first six 11-bit channels leaves on the ch channel, with its index, on the byte
// that completes it. A byte is taken every cycle unless it completes a channel while the
// result register is full and stalled. Each byte passes an input register, one short
// unpacking step and a result register; bytes that complete no channel never wait on it.

`default_nettype none

module sbus_frame_channel_decoder #(
    parameter int unsigned FRAME_LENGTH = sbfd_pkg::FRAME_LENGTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [sbfd_pkg::BYTE_W-1:0]   start_byte,
    input  wire logic                          rx_valid,
    output      logic                          rx_stall,
    input  wire logic [sbfd_pkg::BYTE_W-1:0]   rx_byte,
    output      logic                          ch_valid,
    input  wire logic                          ch_stall,
    output      logic [sbfd_pkg::CHAN_IDX_W-1:0] channel_index,
    output      logic [sbfd_pkg::CHAN_VAL_W-1:0] channel_value
);
    import sbfd_pkg::*;

    localparam logic [COUNT_W:0] FRAME_LEN_C = (COUNT_W+1)'(FRAME_LENGTH);
    localparam logic [COUNT_W-1:0] KEPT_C    = COUNT_W'(KEPT_BYTES);

    logic [BYTE_W-1:0]     start_byte_reg;
    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [COUNT_W:0]      count_inc;
    frame_byte_t           frame_bytes_reg [KEPT_BYTES];
    logic                  out_valid_reg;
    chan_idx_t             out_index_reg;
    logic [CHAN_VAL_W-1:0] out_value_reg;

    logic                  in_frame;
    logic                  out_free;
    logic                  advance;
    chan_result_t          result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            start_byte_reg <= start_byte;
        end
    end

    // a byte counts as frame data when a frame is open or it opens one
    assign in_frame  = (count_reg != '0) || (in_byte_reg == start_byte_reg);
    assign count_inc = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign count_next = (count_inc >= FRAME_LEN_C) ? '0 : count_inc[COUNT_W-1:0];

    sbfd_unpack u_unpack (
        .count_inc   (count_inc),
        .cur_byte    (in_byte_reg),
        .frame_bytes (frame_bytes_reg),
        .result      (result)
    );

    assign out_free = !out_valid_reg || !ch_stall;
    assign advance  = in_valid_reg && (out_free || !(in_frame && result.hit));
    assign rx_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance && in_frame)
        begin
            count_reg <= count_next;
        end
    end

    // only the first bytes of the frame carry the decoded channels
    always_ff @(posedge clk)
    begin
        if (advance && in_frame && (count_reg < KEPT_C))
        begin
            frame_bytes_reg[count_reg[KEPT_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_frame && result.hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!ch_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_frame && result.hit)
        begin
            out_index_reg <= result.index;
            out_value_reg <= result.value;
        end
    end

    assign ch_valid      = out_valid_reg;
    assign channel_index = out_index_reg;
    assign channel_value = out_value_reg;

endmodule

`default_nettype wire
